>>> rtl/pcicfg_pkg.sv
// ----------------------------------------------------------------------------
// pcicfg_pkg: shared types and constants of the PCI configuration access block
// Command and status codes, I/O port numbers, reset values and the record that
// carries one item from the access stage to the lane select stage.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

  // Default configuration of the block
  localparam int unsigned MAX_DEVICES_DEF  = 8;
  localparam int unsigned CONFIG_BYTES_DEF = 256;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;

  // I/O ports of configuration mechanism 1
  localparam logic [15:0] ADDR_PORT = 16'h0CF8;
  localparam logic [15:0] DATA_PORT = 16'h0CFC;

  // Data value that arms the BAR0 size probe
  localparam logic [31:0] PROBE_VALUE = 32'hFFFF_FFFF;

  // Allocator reset values and limits
  localparam logic [16:0] IO_BASE_RESET = 17'h0A000;
  localparam logic [4:0]  IRQ_FIRST     = 5'd12;
  localparam logic [4:0]  IRQ_LIMIT     = 5'd16;

  // Header layout (dword indexes)
  localparam int unsigned HB_CLASS_DWORD = 2;   // class byte sits at offset 0x0B
  localparam logic [31:0] HB_CLASS_WORD  = 32'h0600_0000;
  localparam int unsigned BAR0_DWORD     = 4;   // offset 0x10
  localparam logic [5:0]  INTR_DWORD     = 6'd15; // offsets 0x3C/0x3D
  localparam logic [7:0]  INTR_PIN       = 8'h01;

  typedef enum logic [1:0] {
    CMD_IO_READ  = 2'd0,
    CMD_IO_WRITE = 2'd1,
    CMD_ADD_DEV  = 2'd2,
    CMD_LOAD_CFG = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNHANDLED = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_IRQ    = 3'd4
  } status_e;

  // One item on its way from the access stage to the lane select stage
  typedef struct packed {
    status_e     status;
    logic [2:0]  aslot;
    logic [16:0] abase;
    logic [3:0]  airq;
    logic        use_mem;   // result comes from the config memory dword
    logic [31:0] direct;    // result when use_mem is low
    logic [1:0]  off;       // byte offset within the dword
    logic [2:0]  size;
    logic [3:0]  lane_ok;   // byte lane lies inside config space
    logic        ovl_hit;   // interrupt line/pin bytes come from the overlay
    logic [15:0] ovl;
  } stage_t;

endpackage

>>> rtl/pcicfg_ram.sv
// ----------------------------------------------------------------------------
// pcicfg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when re_i is low.
// ----------------------------------------------------------------------------
module pcicfg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pcicfg_access.sv
// ----------------------------------------------------------------------------
// pcicfg_access: input register, block state and config memory control
// Decodes the registered item, updates latch, probe and allocator state, and
// issues the config memory read, and any write, that the item needs.
// ----------------------------------------------------------------------------
module pcicfg_access #(
  parameter int unsigned MAX_DEVICES  = pcicfg_pkg::MAX_DEVICES_DEF,
  parameter int unsigned CONFIG_BYTES = pcicfg_pkg::CONFIG_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = pcicfg_pkg::PAGE_BYTES_DEF,
  localparam int unsigned CFG_DWORDS = CONFIG_BYTES / 4,
  localparam int unsigned DEPTH      = MAX_DEVICES * CFG_DWORDS,
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         port_i,
  input  logic [2:0]          access_size_i,
  input  logic [31:0]         write_value_i,
  input  logic [15:0]         port_length_i,
  input  logic                wants_irq_i,
  input  logic [2:0]          target_slot_i,
  input  logic [5:0]          dword_index_i,
  input  logic                s2_free_i,
  output logic                s1_go_o,
  output pcicfg_pkg::stage_t  stage_o,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [31:0]         ram_wdata_o,
  output logic                ram_re_o,
  output logic [ADDR_W-1:0]   ram_raddr_o
);

  import pcicfg_pkg::*;

  localparam int unsigned SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned DC_W   = $clog2(MAX_DEVICES + 1);
  // Ceiling reciprocal of the page size; floor(x * PAGE_RECIP / 2^34) equals
  // floor(x / PAGE_BYTES) for every x below 2^17 and page sizes up to 4096.
  localparam longint unsigned PAGE_RECIP =
    ((64'd1 << 34) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
  localparam logic [30:0] PAGE_RECIP_W = 31'(PAGE_RECIP);

  // Input register
  logic        s1_v_q;
  logic [1:0]  s1_cmd_q;
  logic [15:0] s1_port_q;
  logic [2:0]  s1_size_q;
  logic [31:0] s1_wval_q;
  logic [15:0] s1_plen_q;
  logic        s1_wirq_q;
  logic [2:0]  s1_tslot_q;
  logic [5:0]  s1_didx_q;
  logic [13:0] s1_pages_q;

  // Block state
  logic [31:0]     latch_q, latch_d;
  logic            probe_q, probe_d;
  logic [DC_W-1:0] dc_q, dc_d;
  logic [16:0]     nbase_q, nbase_d;
  logic [4:0]      nirq_q, nirq_d;
  logic [15:0]     win_len_q [MAX_DEVICES];
  logic [15:0]     win_len_d [MAX_DEVICES];
  logic [15:0]     ovl_q [MAX_DEVICES];
  logic [15:0]     ovl_d [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] ovl_v_q, ovl_v_d;

  // Clearing pass over the config memory
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic        accept;
  logic        s1_go;
  logic [16:0] pg_x;
  logic [47:0] pg_prod;
  logic [16:0] grow;
  logic        size_ok;
  logic        is_data_port;
  logic [5:0]  lslot6;
  logic [SLOT_W-1:0] lidx;
  logic        populated;
  logic [7:0]  off_raw;
  logic [7:0]  off8;
  logic [5:0]  dw;
  logic [3:0]  lane_ok;
  logic [5:0]  dc6;
  logic [SLOT_W-1:0] dcidx;
  logic [5:0]  t6;
  logic [SLOT_W-1:0] tidx;
  logic        load_ok;
  stage_t      st;
  logic        s_we;
  logic [ADDR_W-1:0] s_waddr;
  logic [31:0] s_wdata;

  assign s1_go      = s1_v_q && s2_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = clr_busy_q || (s1_v_q && !s2_free_i);
  assign s1_go_o    = s1_go;

  // Page count of the window, taken at accept
  assign pg_x    = 17'(port_length_i) + 17'(PAGE_BYTES - 1);
  assign pg_prod = {31'd0, pg_x} * {17'd0, PAGE_RECIP_W};
  assign grow    = 17'(32'(s1_pages_q) * 32'(PAGE_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_go) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= command_i;
      s1_port_q  <= port_i;
      s1_size_q  <= access_size_i;
      s1_wval_q  <= write_value_i;
      s1_plen_q  <= port_length_i;
      s1_wirq_q  <= wants_irq_i;
      s1_tslot_q <= target_slot_i;
      s1_didx_q  <= dword_index_i;
      s1_pages_q <= pg_prod[47:34];
    end
  end

  // Address decode
  assign size_ok = (s1_size_q == 3'd1) || (s1_size_q == 3'd2) || (s1_size_q == 3'd4);
  assign is_data_port = (s1_port_q[15:2] == DATA_PORT[15:2]);
  assign lslot6    = latch_q[16:11];
  assign lidx      = lslot6[SLOT_W-1:0];
  assign populated = (latch_q[23:16] == 8'h00) && (lslot6 < 6'(dc_q)) &&
                     (int'(lslot6) < MAX_DEVICES);
  assign off_raw   = latch_q[7:0] + {6'd0, s1_port_q[1:0]};
  always_comb begin
    off8 = off_raw;
    if (s1_size_q == 3'd2) begin
      off8[0] = 1'b0;
    end else if (s1_size_q == 3'd4) begin
      off8[1:0] = 2'b00;
    end
  end
  assign dw = off8[7:2];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_ok[k] = (int'({dw, 2'(k)}) < CONFIG_BYTES);
    end
  end
  assign dc6     = 6'(dc_q);
  assign dcidx   = dc6[SLOT_W-1:0];
  assign t6      = {3'd0, s1_tslot_q};
  assign tidx    = t6[SLOT_W-1:0];
  assign load_ok = (int'(s1_tslot_q) < MAX_DEVICES) && (int'(s1_didx_q) < CFG_DWORDS);

  assign ram_re_o    = s1_go;
  assign ram_raddr_o = (int'(dw) < CFG_DWORDS) ?
                       ADDR_W'(int'(lidx) * CFG_DWORDS + int'(dw)) : '0;

  always_comb begin
    latch_d  = latch_q;
    probe_d  = probe_q;
    dc_d     = dc_q;
    nbase_d  = nbase_q;
    nirq_d   = nirq_q;
    win_len_d = win_len_q;
    ovl_d    = ovl_q;
    ovl_v_d  = ovl_v_q;
    st       = '0;
    st.status = ST_OK;
    st.off   = off8[1:0];
    st.size  = s1_size_q;
    st.lane_ok = lane_ok;
    st.ovl   = ovl_q[lidx];
    s_we     = 1'b0;
    s_waddr  = '0;
    s_wdata  = '0;
    if (s1_go) begin
      unique case (cmd_e'(s1_cmd_q))
        CMD_IO_READ: begin
          if (!size_ok) begin
            st.status = ST_BAD_SIZE;
          end else if (s1_port_q == ADDR_PORT) begin
            st.direct = latch_q;
          end else if (is_data_port) begin
            if (populated) begin
              if (probe_q) begin
                probe_d   = 1'b0;
                st.direct = {16'd0, win_len_q[lidx]};
              end else begin
                st.use_mem = 1'b1;
                st.ovl_hit = ovl_v_q[lidx] && (dw == INTR_DWORD);
              end
            end
          end else begin
            st.status = ST_UNHANDLED;
          end
        end
        CMD_IO_WRITE: begin
          if (!size_ok) begin
            st.status = ST_BAD_SIZE;
          end else if (s1_port_q == ADDR_PORT) begin
            latch_d = s1_wval_q;
          end else if (s1_port_q == DATA_PORT) begin
            if (s1_wval_q == PROBE_VALUE) begin
              probe_d = 1'b1;
            end
          end else begin
            st.status = ST_UNHANDLED;
          end
        end
        CMD_ADD_DEV: begin
          if (dc_q >= DC_W'(MAX_DEVICES)) begin
            st.status = ST_FULL;
          end else if (s1_wirq_q && (nirq_q >= IRQ_LIMIT)) begin
            st.status = ST_NO_IRQ;
          end else begin
            st.aslot = 3'(dc_q);
            st.abase = nbase_q;
            win_len_d[dcidx] = s1_plen_q;
            if (s1_plen_q != 16'd0) begin
              s_we    = 1'b1;
              s_waddr = ADDR_W'(int'(dcidx) * CFG_DWORDS + BAR0_DWORD);
              s_wdata = {15'd0, nbase_q} | 32'd1;
            end
            if (s1_wirq_q) begin
              st.airq        = nirq_q[3:0];
              nirq_d         = nirq_q + 5'd1;
              ovl_d[dcidx]   = {INTR_PIN, 4'd0, nirq_q[3:0]};
              ovl_v_d[dcidx] = 1'b1;
            end
            nbase_d = nbase_q + grow;
            dc_d    = dc_q + DC_W'(1);
          end
        end
        CMD_LOAD_CFG: begin
          if (load_ok) begin
            s_we    = 1'b1;
            s_waddr = ADDR_W'(int'(tidx) * CFG_DWORDS + int'(s1_didx_q));
            s_wdata = s1_wval_q;
            if (s1_didx_q == INTR_DWORD) begin
              ovl_v_d[tidx] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stage_o = st;

  // Memory write port: the clearing pass owns it until it finishes
  always_comb begin
    if (clr_busy_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_cnt_q;
      ram_wdata_o = (clr_cnt_q == ADDR_W'(HB_CLASS_DWORD)) ? HB_CLASS_WORD : '0;
    end else begin
      ram_we_o    = s_we;
      ram_waddr_o = s_waddr;
      ram_wdata_o = s_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      probe_q <= 1'b0;
      dc_q    <= DC_W'(1);
      nbase_q <= IO_BASE_RESET;
      nirq_q  <= IRQ_FIRST;
      ovl_v_q <= '0;
      for (int i = 0; i < MAX_DEVICES; i++) begin
        win_len_q[i] <= '0;
      end
    end else begin
      latch_q   <= latch_d;
      probe_q   <= probe_d;
      dc_q      <= dc_d;
      nbase_q   <= nbase_d;
      nirq_q    <= nirq_d;
      ovl_v_q   <= ovl_v_d;
      win_len_q <= win_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovl_q <= ovl_d;
  end

endmodule

>>> rtl/pcicfg_lane.sv
// ----------------------------------------------------------------------------
// pcicfg_lane: byte lane select and result register
// Merges the interrupt overlay into the memory dword, picks the addressed
// bytes and holds the finished result until the output side takes it.
// ----------------------------------------------------------------------------
module pcicfg_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_go_i,
  input  pcicfg_pkg::stage_t stage_i,
  input  logic [31:0]        ram_rdata_i,
  output logic               s2_free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        read_data_o,
  output logic [2:0]         status_o,
  output logic [2:0]         assigned_slot_o,
  output logic [16:0]        assigned_io_base_o,
  output logic [3:0]         assigned_irq_o
);

  import pcicfg_pkg::*;

  logic        s2_v_q;
  stage_t      s2_q;
  logic        out_v_q;
  logic        out_ready;
  logic [31:0] word;
  logic [31:0] sel;
  logic [31:0] rdata;

  assign out_ready = !out_v_q || !out_stall_i;
  assign s2_free_o = !s2_v_q || out_ready;

  always_comb begin
    logic [1:0] k;
    word = ram_rdata_i;
    if (s2_q.ovl_hit) begin
      word[15:0] = s2_q.ovl;
    end
    for (int i = 0; i < 4; i++) begin
      k = s2_q.off + 2'(i);
      if ((3'(i) < s2_q.size) && s2_q.lane_ok[k]) begin
        sel[i*8 +: 8] = word[{k, 3'b000} +: 8];
      end else begin
        sel[i*8 +: 8] = 8'h00;
      end
    end
  end

  assign rdata = s2_q.use_mem ? sel : s2_q.direct;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_free_o) begin
        s2_v_q <= s1_go_i;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go_i) begin
      s2_q <= stage_i;
    end
    if (out_ready && s2_v_q) begin
      read_data_o        <= rdata;
      status_o           <= s2_q.status;
      assigned_slot_o    <= s2_q.aslot;
      assigned_io_base_o <= s2_q.abase;
      assigned_irq_o     <= s2_q.airq;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

>>> rtl/pci_config_space_access_top.sv
// ----------------------------------------------------------------------------
// pci_config_space_access_top: PCI configuration mechanism 1 with allocator
// Address latch at 0xCF8, sized data reads at 0xCFC-0xCFF, one-shot BAR0 size
// probe, and a device allocator for slots, I/O bases and IRQ lines.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | in_valid_i / in_stall_o | command, port, access_size,
//          |           |                        | write_value, port_length,
//          |           |                        | wants_irq, target_slot,
//          |           |                        | dword_index
//  out     | out       | out_valid_o / out_stall_i | read_data, status,
//          |           |                        | assigned_slot/io_base/irq
//
//  One item per cycle sustained while out_stall_i is low and no clearing pass
//  runs; each item makes one config memory read through the single read port,
//  and an add or a load may also write through the single write port. An
//  accepted item sits in the input register, moves with its memory read into
//  the lane stage and then reaches the result register, which drives out_valid_o.
//  After reset a clearing pass writes every config memory entry, one a cycle,
//  MAX_DEVICES * CONFIG_BYTES / 4 entries (512 by default), in_stall_o high.
//  A stalled result holds in the result register; the stages behind it fill
//  and in_stall_o rises only when the input register cannot move on.
//
module pci_config_space_access_top #(
  parameter int unsigned MAX_DEVICES  = pcicfg_pkg::MAX_DEVICES_DEF,
  parameter int unsigned CONFIG_BYTES = pcicfg_pkg::CONFIG_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = pcicfg_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] port_i,
  input  logic [2:0]  access_size_i,
  input  logic [31:0] write_value_i,
  input  logic [15:0] port_length_i,
  input  logic        wants_irq_i,
  input  logic [2:0]  target_slot_i,
  input  logic [5:0]  dword_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic [2:0]  status_o,
  output logic [2:0]  assigned_slot_o,
  output logic [16:0] assigned_io_base_o,
  output logic [3:0]  assigned_irq_o
);

  import pcicfg_pkg::*;

  localparam int unsigned CFG_DWORDS = CONFIG_BYTES / 4;
  localparam int unsigned DEPTH      = MAX_DEVICES * CFG_DWORDS;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              s1_go;
  logic              s2_free;
  stage_t            stage;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // Decode, state update and memory control
  pcicfg_access #(
    .MAX_DEVICES  (MAX_DEVICES),
    .CONFIG_BYTES (CONFIG_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_access (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .port_i        (port_i),
    .access_size_i (access_size_i),
    .write_value_i (write_value_i),
    .port_length_i (port_length_i),
    .wants_irq_i   (wants_irq_i),
    .target_slot_i (target_slot_i),
    .dword_index_i (dword_index_i),
    .s2_free_i     (s2_free),
    .s1_go_o       (s1_go),
    .stage_o       (stage),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  // Config space of all slots, one dword per entry
  pcicfg_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Byte lane select and result register
  pcicfg_lane u_lane (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s1_go_i            (s1_go),
    .stage_i            (stage),
    .ram_rdata_i        (ram_rdata),
    .s2_free_o          (s2_free),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .status_o           (status_o),
    .assigned_slot_o    (assigned_slot_o),
    .assigned_io_base_o (assigned_io_base_o),
    .assigned_irq_o     (assigned_irq_o)
  );

  // A rejected access returns no data and assigns nothing
  a_bad_size_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD_SIZE) |->
      (read_data_o == 32'd0) && (assigned_irq_o == 4'd0))
    else $error("bad size result carries data");

  // IRQ lines are only handed out from the top range, on a successful add
  a_irq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (assigned_irq_o != 4'd0) |->
      (assigned_irq_o >= 4'd12) && (status_o == ST_OK))
    else $error("irq out of range or on failed item");

  // A failed item never reports an I/O base
  a_fail_no_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (assigned_io_base_o == 17'd0))
    else $error("io base on failed item");

  // Nothing enters while the memory clearing pass runs right after reset
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open during clearing pass");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the PCI configuration mechanism 1 block
// Runs short directed tests on the address latch, the error codes, the byte
// lanes, the device allocator and the BAR0 size probe. It then sends random
// traffic built mostly from latch-then-read sequences. A predictor mirrors the
// block's state and checks every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcicfg_pkg::*;

  localparam int unsigned NDEV         = MAX_DEVICES_DEF;
  localparam int unsigned CFG_DW       = CONFIG_BYTES_DEF / 4;
  localparam int unsigned PAGE         = PAGE_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 800;
  // Covers the clearing pass plus every item meeting the longest gap and stall
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One input item as the sender sees it
  typedef struct {
    cmd_e        cmd;
    logic [15:0] port;
    logic [2:0]  size;
    logic [31:0] wval;
    logic [15:0] plen;
    logic        wirq;
    logic [2:0]  tslot;
    logic [5:0]  didx;
  } io_access_t;

  // One result item
  typedef struct {
    logic [31:0] rdata;
    status_e     status;
    logic [2:0]  slot;
    logic [16:0] base;
    logic [3:0]  irq;
  } cfg_response_t;

  // Clock, reset and block inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  command_i     = '0;
  logic [15:0] port_i        = '0;
  logic [2:0]  access_size_i = '0;
  logic [31:0] write_value_i = '0;
  logic [15:0] port_length_i = '0;
  logic        wants_irq_i   = 1'b0;
  logic [2:0]  target_slot_i = '0;
  logic [5:0]  dword_index_i = '0;
  logic        out_stall_i   = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] read_data_o;
  logic [2:0]  status_o;
  logic [2:0]  assigned_slot_o;
  logic [16:0] assigned_io_base_o;
  logic [3:0]  assigned_irq_o;

  // Predictor state: mirrors the block after reset
  logic [31:0] cfg_addr     = '0;
  logic        probe_armed  = 1'b0;
  logic [3:0]  dev_count    = 4'd1;   // slot 0 is the host bridge
  logic [16:0] io_base_next = IO_BASE_RESET;
  logic [4:0]  irq_next     = IRQ_FIRST;
  logic [15:0] win_len    [NDEV];
  logic [31:0] cfg_dwords [NDEV * CFG_DW];

  cfg_response_t pending_responses[$];
  int unsigned   access_count   = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   stall_run      = 0;
  bit            no_idle        = 1'b0;

  pci_config_space_access_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .port_i             (port_i),
    .access_size_i      (access_size_i),
    .write_value_i      (write_value_i),
    .port_length_i      (port_length_i),
    .wants_irq_i        (wants_irq_i),
    .target_slot_i      (target_slot_i),
    .dword_index_i      (dword_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .status_o           (status_o),
    .assigned_slot_o    (assigned_slot_o),
    .assigned_io_base_o (assigned_io_base_o),
    .assigned_irq_o     (assigned_irq_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  // Inside a quiet stretch both sides run flat out.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (no_idle || roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [2:0] legal_size();
    case ($urandom_range(0, 2))
      0:       return 3'd1;
      1:       return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

  // Fully random item; ports cluster around the config ports half the time
  function automatic io_access_t noise_item();
    io_access_t a;
    a.cmd   = cmd_e'($urandom_range(0, 3));
    a.port  = $urandom_range(0, 1) ? 16'($urandom_range(16'hCF6, 16'hD01)) : 16'($urandom);
    a.size  = 3'($urandom_range(0, 7));
    a.wval  = ($urandom_range(0, 7) == 0) ? PROBE_VALUE : 32'($urandom);
    a.plen  = 16'($urandom);
    a.wirq  = 1'($urandom);
    a.tslot = 3'($urandom);
    a.didx  = 6'($urandom);
    return a;
  endfunction

  // Latch value: mostly bus 0 and a low slot, so that data reads hit devices
  function automatic logic [31:0] random_latch();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 7) != 0) begin
      v[23:16] = 8'h00;
      if ($urandom_range(0, 3) != 0) v[15:14] = 2'b00;
    end
    return v;
  endfunction

  // Advance the mirrored state by one accepted item and return its result
  function automatic cfg_response_t predict_response(input io_access_t a);
    cfg_response_t r;
    logic [5:0]    slot;
    logic [7:0]    off;
    int unsigned   row;
    int unsigned   grow;
    int unsigned   b;
    r.rdata  = '0;
    r.status = ST_OK;
    r.slot   = '0;
    r.base   = '0;
    r.irq    = '0;
    case (a.cmd)
      CMD_IO_READ, CMD_IO_WRITE: begin
        if (a.size != 3'd1 && a.size != 3'd2 && a.size != 3'd4) begin
          // size is checked ahead of the port
          r.status = ST_BAD_SIZE;
        end else if (a.port == ADDR_PORT) begin
          if (a.cmd == CMD_IO_READ) r.rdata = cfg_addr;
          else cfg_addr = a.wval;
        end else if (a.cmd == CMD_IO_WRITE) begin
          // only the base data port takes writes, and only the probe value matters
          if (a.port != DATA_PORT) r.status = ST_UNHANDLED;
          else if (a.wval == PROBE_VALUE) probe_armed = 1'b1;
        end else if (a.port < DATA_PORT || a.port > DATA_PORT + 16'd3) begin
          r.status = ST_UNHANDLED;
        end else begin
          slot = cfg_addr[16:11];
          off  = cfg_addr[7:0] + 8'(a.port - DATA_PORT);
          // empty slot or other bus: read zero and keep the probe armed
          if (cfg_addr[23:16] == 8'h00 && slot < dev_count && slot < NDEV) begin
            if (probe_armed) begin
              probe_armed = 1'b0;
              r.rdata = 32'(win_len[slot]);
            end else begin
              if (a.size == 3'd2) off[0] = 1'b0;
              else if (a.size == 3'd4) off[1:0] = 2'b00;
              for (int i = 0; i < int'(a.size); i++) begin
                b = off + i;
                if (b < CONFIG_BYTES_DEF)
                  r.rdata[8*i +: 8] = cfg_dwords[slot * CFG_DW + b / 4][8 * (b % 4) +: 8];
              end
            end
          end
        end
      end
      CMD_ADD_DEV: begin
        if (dev_count >= NDEV) begin
          r.status = ST_FULL;
        end else if (a.wirq && irq_next >= IRQ_LIMIT) begin
          r.status = ST_NO_IRQ;
        end else begin
          row  = dev_count * CFG_DW;
          grow = ((a.plen + PAGE - 1) / PAGE) * PAGE;
          r.slot = 3'(dev_count);
          r.base = io_base_next;
          win_len[dev_count] = a.plen;
          if (a.plen != 16'd0) cfg_dwords[row + BAR0_DWORD] = {15'b0, io_base_next} | 32'd1;
          if (a.wirq) begin
            r.irq = irq_next[3:0];
            cfg_dwords[row + INTR_DWORD][7:0]  = {3'b000, irq_next};
            cfg_dwords[row + INTR_DWORD][15:8] = INTR_PIN;
            irq_next = irq_next + 5'd1;
          end
          io_base_next = 17'(io_base_next + grow);
          dev_count = dev_count + 4'd1;
        end
      end
      CMD_LOAD_CFG: begin
        // loads land even in slots that hold no device yet
        if (a.tslot < NDEV && a.didx < CFG_DW) cfg_dwords[a.tslot * CFG_DW + a.didx] = a.wval;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item: idle a while, present it, hold it until the block takes it.
  // Call at a rising edge; returns at the edge that accepts the item.
  task automatic send_access(input io_access_t a);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= a.cmd;
    port_i        <= a.port;
    access_size_i <= a.size;
    write_value_i <= a.wval;
    port_length_i <= a.plen;
    wants_irq_i   <= a.wirq;
    target_slot_i <= a.tslot;
    dword_index_i <= a.didx;
    // sample the handshake mid-cycle, where it has settled
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    pending_responses.push_back(predict_response(a));
    access_count++;
    @(posedge clk_i);
  endtask

  // I/O access; fields that the command ignores stay random
  task automatic send_io(input cmd_e c, input logic [15:0] p, input logic [2:0] s,
                         input logic [31:0] v);
    io_access_t a;
    a      = noise_item();
    a.cmd  = c;
    a.port = p;
    a.size = s;
    a.wval = v;
    send_access(a);
  endtask

  task automatic send_add(input logic [15:0] plen, input logic wirq);
    io_access_t a;
    a      = noise_item();
    a.cmd  = CMD_ADD_DEV;
    a.plen = plen;
    a.wirq = wirq;
    send_access(a);
  endtask

  task automatic send_load(input logic [2:0] slot, input logic [5:0] idx, input logic [31:0] v);
    io_access_t a;
    a       = noise_item();
    a.cmd   = CMD_LOAD_CFG;
    a.tslot = slot;
    a.didx  = idx;
    a.wval  = v;
    send_access(a);
  endtask

  // Address latch round trip, bad sizes and unhandled ports
  task automatic test_latch_and_errors();
    send_io(CMD_IO_READ,  ADDR_PORT, 3'd4, 32'h0);
    send_io(CMD_IO_WRITE, ADDR_PORT, 3'd1, 32'hFFFF_FFFF);  // a byte write still stores all
    send_io(CMD_IO_READ,  ADDR_PORT, 3'd2, 32'h0);
    send_io(CMD_IO_READ,  DATA_PORT, 3'd4, 32'h0);          // bus 0xFF reads zero
    send_io(CMD_IO_READ,  ADDR_PORT, 3'd0, 32'h0);
    send_io(CMD_IO_WRITE, 16'hFFFF,  3'd7, 32'h0);          // size wins over port
    send_io(CMD_IO_READ,  16'h0000,  3'd1, 32'h0);
    send_io(CMD_IO_WRITE, DATA_PORT + 16'd1, 3'd4, PROBE_VALUE);  // must not arm
  endtask

  // Byte lanes of the host bridge, offset wrap past 0xFF
  task automatic test_config_reads();
    send_load(3'd0, 6'd63, 32'hDEAD_BEEF);
    send_io(CMD_IO_WRITE, ADDR_PORT, 3'd4, 32'h8000_00FF);
    send_io(CMD_IO_READ,  DATA_PORT, 3'd1, 32'h0);
    send_io(CMD_IO_READ,  DATA_PORT + 16'd3, 3'd1, 32'h0);
    send_io(CMD_IO_WRITE, ADDR_PORT, 3'd2, 32'h8000_0008);
    send_io(CMD_IO_READ,  DATA_PORT + 16'd3, 3'd2, 32'h0);  // class code lane
  endtask

  // Fill the device table: empty window, largest windows with base wrap,
  // running out of IRQ lines, then a full table
  task automatic test_allocator();
    send_add(16'h0000, 1'b1);
    send_add(16'hFFFF, 1'b1);
    send_add(16'hFFFF, 1'b1);
    send_add(16'h0001, 1'b1);
    send_add(16'h1000, 1'b1);
    send_add(16'h1001, 1'b0);
    send_add(16'($urandom), 1'b0);
    send_add(16'($urandom), 1'b0);
    send_add(16'h0010, 1'b0);
  endtask

  // Arm the probe, miss on another bus (stays armed), then hit a device
  task automatic test_size_probe();
    send_io(CMD_IO_WRITE, DATA_PORT, 3'd4, PROBE_VALUE);
    send_io(CMD_IO_WRITE, ADDR_PORT, 3'd4, 32'h8001_1010);
    send_io(CMD_IO_READ,  DATA_PORT, 3'd4, 32'h0);
    send_io(CMD_IO_WRITE, ADDR_PORT, 3'd4, 32'h8000_1010);
    send_io(CMD_IO_READ,  DATA_PORT + 16'd2, 3'd1, 32'h0);
    send_io(CMD_IO_READ,  DATA_PORT, 3'd4, 32'h0);          // BAR0 once disarmed
  endtask

  // Mostly well-formed sequences with random content, the rest noise
  task automatic test_random_traffic();
    io_access_t  a;
    int unsigned stop_at;
    int unsigned next_mode;
    int unsigned kind;
    int unsigned reads;
    stop_at   = access_count + RANDOM_ITEMS;
    next_mode = access_count;
    while (access_count < stop_at) begin
      // switch between idling and flat-out stretches
      if (access_count >= next_mode) begin
        no_idle   = ($urandom_range(0, 3) == 0);
        next_mode = access_count + 50;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_io(CMD_IO_WRITE, ADDR_PORT, legal_size(), random_latch());
        reads = $urandom_range(1, 3);
        repeat (reads)
          send_io(CMD_IO_READ, DATA_PORT + 16'($urandom_range(0, 3)), legal_size(), $urandom);
      end else if (kind < 55) begin
        send_io(CMD_IO_WRITE, ADDR_PORT, legal_size(), random_latch());
        send_io(CMD_IO_WRITE, DATA_PORT, legal_size(), PROBE_VALUE);
        send_io(CMD_IO_READ, DATA_PORT + 16'($urandom_range(0, 3)), legal_size(), $urandom);
      end else if (kind < 70) begin
        // load a dword, then read it back through the latch
        a = noise_item();
        a.cmd = CMD_LOAD_CFG;
        send_access(a);
        send_io(CMD_IO_WRITE, ADDR_PORT, legal_size(),
                32'h8000_0000 | (32'(a.tslot) << 11) | (32'(a.didx) << 2));
        send_io(CMD_IO_READ, DATA_PORT + 16'($urandom_range(0, 3)), 3'd4, $urandom);
      end else if (kind < 82) begin
        send_io($urandom_range(0, 1) ? CMD_IO_READ : CMD_IO_WRITE,
                $urandom_range(0, 1) ? ADDR_PORT : DATA_PORT + 16'($urandom_range(0, 3)),
                legal_size(), $urandom);
      end else if (kind < 87) begin
        a = noise_item();
        a.cmd = CMD_ADD_DEV;
        send_access(a);
      end else begin
        send_access(noise_item());
      end
    end
    no_idle = 1'b0;
  endtask

  // Report one field
  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Result side: drop stall for one cycle, then hold it for a random run
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run = stall_run - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = pick_gap();
    end
  end

  // Check each result mid-cycle, ahead of the edge that takes it
  always @(negedge clk_i) begin : result_check
    cfg_response_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item, expected none, actual read_data %0h status %0d",
                 $time, read_data_o, status_o);
      end else begin
        want = pending_responses.pop_front();
        compare_field("read_data", want.rdata, read_data_o);
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("assigned_slot", 32'(want.slot), 32'(assigned_slot_o));
        compare_field("assigned_io_base", 32'(want.base), 32'(assigned_io_base_o));
        compare_field("assigned_irq", 32'(want.irq), 32'(assigned_irq_o));
      end
    end
  end

  // Watchdog: a hang or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    // Mirror the reset contents: all zero but the host bridge class byte
    for (int i = 0; i < NDEV * CFG_DW; i++) cfg_dwords[i] = '0;
    foreach (win_len[i]) win_len[i] = '0;
    cfg_dwords[HB_CLASS_DWORD] = HB_CLASS_WORD;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass after reset shows up as a long input stall
    test_latch_and_errors();
    test_config_reads();
    test_allocator();
    test_size_probe();
    test_random_traffic();
    in_valid_i <= 1'b0;

    // Drain, then wait for stray results to show up
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> pci_config_space_access_top.f
rtl/pcicfg_pkg.sv
rtl/pcicfg_ram.sv
rtl/pcicfg_access.sv
rtl/pcicfg_lane.sv
rtl/pci_config_space_access_top.sv
tb/tb_top.sv
